@@ src/mvt_pkg.sv @@
package mvt_pkg;

  // Pipeline depth from input register to output register.
  localparam int NUM_STAGES = 7;

  localparam int CFG_DATA_W = 64;

  // Axis components are signed Q2.19; trig and scale words are 32 bits.
  localparam int AXIS_W     = 21;
  localparam int AXIS_FRAC  = 19;
  localparam int COEF_W     = 32;
  localparam int SCALE_FRAC = 16;
  localparam int TRIG_FRAC  = 30;

  localparam logic signed [COEF_W:0] ONE_Q30 = 33'sd1073741824;

  localparam logic [3*AXIS_W-1:0]      AXIS_RESET  = 63'd524288;
  localparam logic signed [COEF_W-1:0] SCALE_RESET = 32'sd65536;
  localparam logic signed [COEF_W-1:0] COS_RESET   = 32'sd1073741824;
  localparam logic signed [COEF_W-1:0] SIN_RESET   = 32'sd0;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_PASS      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_MODE         = 3'd0,
    CFG_OFFSET_X     = 3'd1,
    CFG_OFFSET_Y     = 3'd2,
    CFG_OFFSET_Z     = 3'd3,
    CFG_UNIT_AXIS    = 3'd4,
    CFG_SCALE_FACTOR = 3'd5,
    CFG_COS_ANGLE    = 3'd6,
    CFG_SIN_ANGLE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    mode_t                     mode;
    logic [3*AXIS_W-1:0]       axis;
    logic signed [COEF_W-1:0]  scale;
    logic signed [COEF_W-1:0]  cos;
    logic signed [COEF_W-1:0]  sin;
  } cfg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

endpackage

@@ src/mvt_in_if.sv @@
interface mvt_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

@@ src/mvt_out_if.sv @@
interface mvt_out_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          clipped;

  modport source (output valid, output out_x, output out_y, output out_z, output clipped,
                  input ready);
  modport sink (input valid, input out_x, input out_y, input out_z, input clipped,
                output ready);
endinterface

@@ src/mvt_cfg_if.sv @@
interface mvt_cfg_if;
  logic                              valid;
  logic                              ready;
  mvt_pkg::cfg_idx_t                 index;
  logic [mvt_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/mvt_round.sv @@
module mvt_round #(
  parameter int IW = 48,
  parameter int SH = 16
) (
  input  logic signed [IW-1:0] din,
  output logic signed [IW-SH:0] dout
);
  logic signed [IW:0] sum;

  // Add half an LSB of the result, then drop the fraction (round half up).
  assign sum  = $signed({din[IW-1], din})
              + $signed({{(IW-SH+1){1'b0}}, 1'b1, {(SH-1){1'b0}}});
  assign dout = sum[IW:SH];
endmodule

@@ src/mvt_cfg_regs.sv @@
module mvt_cfg_regs #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mvt_cfg_if.sink                       cfg_wr,
  output mvt_pkg::cfg_t                 cfg,
  output logic signed [COORD_WIDTH-1:0] off [3]
);
  import mvt_pkg::*;

  cfg_t                          cfg_r;
  logic signed [COORD_WIDTH-1:0] off_r [3];

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_TRANSLATE;
      cfg_r.axis  <= AXIS_RESET;
      cfg_r.scale <= SCALE_RESET;
      cfg_r.cos   <= COS_RESET;
      cfg_r.sin   <= SIN_RESET;
      for (int i = 0; i < 3; i++) begin
        off_r[i] <= '0;
      end
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.index)
        CFG_MODE:         cfg_r.mode  <= mode_t'(cfg_wr.data[1:0]);
        CFG_OFFSET_X:     off_r[0]    <= cfg_wr.data[COORD_WIDTH-1:0];
        CFG_OFFSET_Y:     off_r[1]    <= cfg_wr.data[COORD_WIDTH-1:0];
        CFG_OFFSET_Z:     off_r[2]    <= cfg_wr.data[COORD_WIDTH-1:0];
        CFG_UNIT_AXIS:    cfg_r.axis  <= cfg_wr.data[3*AXIS_W-1:0];
        CFG_SCALE_FACTOR: cfg_r.scale <= cfg_wr.data[COEF_W-1:0];
        CFG_COS_ANGLE:    cfg_r.cos   <= cfg_wr.data[COEF_W-1:0];
        CFG_SIN_ANGLE:    cfg_r.sin   <= cfg_wr.data[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;
  assign off = off_r;
endmodule

@@ src/mvt_pipe_ctl.sv @@
module mvt_pipe_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output mvt_pkg::pipe_ctrl_t ctrl
);
  import mvt_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] en;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      en[s] = !vld_r[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (en[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  assign in_ready = en[0];
  assign ctrl.en  = en;
  assign ctrl.vld = vld_r;

  // Items in flight change only by input and output transfers.
  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(vld_r) == $past($countones(vld_r))
      + $past(in_valid && in_ready) - $past(vld_r[NUM_STAGES-1] && out_ready))
    else $error("pipeline item count does not match transfers");

  // Input is refused only when every stage holds an item.
  a_no_held_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> &vld_r)
    else $error("input stalled while a stage is empty");

  // A delivered result with nothing behind it must not be shown again.
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NUM_STAGES-1] && out_ready && !vld_r[NUM_STAGES-2] |=> !vld_r[NUM_STAGES-1])
    else $error("result repeated after transfer");
endmodule

@@ src/mvt_datapath.sv @@
module mvt_datapath #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  mvt_pkg::pipe_ctrl_t           ctrl,
  input  mvt_pkg::cfg_t                 cfg,
  input  logic signed [COORD_WIDTH-1:0] off [3],
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          clipped
);
  import mvt_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int RW   = W + 1;                       // v - c
  localparam int KRW  = AXIS_W + RW;                 // k * r
  localparam int SUMW = KRW + 2;                     // cross and dot sums
  localparam int CW   = SUMW - AXIS_FRAC + 1;        // rounded cross and dot
  localparam int MW   = RW + COEF_W;                 // r * scale or r * cos
  localparam int PSW  = MW - SCALE_FRAC + 1;         // rounded scale product
  localparam int PT   = (PSW > 64) ? 64 : PSW;       // scale product kept to 64 bits
  localparam int RCW  = MW - TRIG_FRAC + 1;          // rounded r * cos
  localparam int LW   = W + 5;                       // per-mode linear term
  localparam int OMCW = COEF_W + 1;                  // 1 - cos
  localparam int TPW  = CW + OMCW;
  localparam int TW   = TPW - TRIG_FRAC + 1;         // t = dot * (1 - cos)
  localparam int CSPW = CW + COEF_W;
  localparam int SW   = CSPW - TRIG_FRAC + 1;        // (k x r) * sin
  localparam int AW   = W + 11;                      // partial sum
  localparam int KTPW = AXIS_W + TW;
  localparam int KTW  = KTPW - AXIS_FRAC + 1;        // k * t
  localparam int FW   = W + 14;                      // final sum before saturation

  localparam logic signed [PT-1:0] SPAN = {{(PT-W-3){1'b0}}, 1'b1, {(W+2){1'b0}}};

  logic signed [W-1:0]      v [3];
  logic signed [AXIS_W-1:0] k [3];
  logic signed [COEF_W-1:0] coef;
  logic signed [OMCW-1:0]   omc;

  // Stage 1: offset removal and the direct result for translate or pass.
  logic signed [RW-1:0]   r1_nxt [3];
  logic signed [RW-1:0]   dir1_nxt [3];
  logic signed [RW-1:0]   r1_r [3];
  logic signed [RW-1:0]   dir1_r [3];
  // Stage 2: axis products and the shared scale / cosine product.
  logic signed [KRW-1:0]  kr2_r [3][3];
  logic signed [MW-1:0]   m2_r [3];
  logic signed [RW-1:0]   dir2_r [3];
  // Stage 3: cross and dot products rounded, linear term resolved.
  logic signed [SUMW-1:0] cross_sum [3];
  logic signed [SUMW-1:0] dot_sum;
  logic signed [CW-1:0]   cr_rnd [3];
  logic signed [CW-1:0]   dot_rnd;
  logic signed [PSW-1:0]  sc_rnd [3];
  logic signed [PT-1:0]   sc_trunc [3];
  logic signed [PT-1:0]   sc_clamp [3];
  logic signed [RCW-1:0]  rc_rnd [3];
  logic signed [LW-1:0]   lin3_nxt [3];
  logic signed [CW-1:0]   cr3_r [3];
  logic signed [CW-1:0]   dot3_r;
  logic signed [LW-1:0]   lin3_r [3];
  // Stage 4: products with (1 - cos) and sin.
  logic signed [TPW-1:0]  tp4_r;
  logic signed [CSPW-1:0] csp4_r [3];
  logic signed [LW-1:0]   lin4_r [3];
  // Stage 5: rounding and the partial sum.
  logic signed [TW-1:0]   t_rnd;
  logic signed [SW-1:0]   cs_rnd [3];
  logic signed [AW-1:0]   acc5_nxt [3];
  logic signed [TW-1:0]   t5_r;
  logic signed [AW-1:0]   acc5_r [3];
  // Stage 6: axis times t.
  logic signed [KTPW-1:0] ktp6_r [3];
  logic signed [AW-1:0]   acc6_r [3];
  // Stage 7: final sum and saturation.
  logic signed [KTW-1:0]  kt_rnd [3];
  logic signed [FW-1:0]   fin [3];
  logic signed [W-1:0]    out_nxt [3];
  logic [2:0]             clip_nxt;
  logic signed [W-1:0]    out7_r [3];
  logic                   clip7_r;

  assign v[0] = in_x;
  assign v[1] = in_y;
  assign v[2] = in_z;

  assign coef = (cfg.mode == MODE_SCALE) ? cfg.scale : cfg.cos;
  assign omc  = ONE_Q30 - OMCW'(cfg.cos);

  assign dot_sum = SUMW'(kr2_r[0][0]) + SUMW'(kr2_r[1][1]) + SUMW'(kr2_r[2][2]);

  mvt_round #(.IW(SUMW), .SH(AXIS_FRAC)) u_dot_rnd (.din(dot_sum), .dout(dot_rnd));
  mvt_round #(.IW(TPW), .SH(TRIG_FRAC)) u_t_rnd (.din(tp4_r), .dout(t_rnd));

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;

    assign k[i] = cfg.axis[AXIS_W*i +: AXIS_W];

    assign r1_nxt[i]   = RW'(v[i]) - RW'(off[i]);
    assign dir1_nxt[i] = (cfg.mode == MODE_TRANSLATE) ? RW'(v[i]) + RW'(off[i]) : RW'(v[i]);

    assign cross_sum[i] = SUMW'(kr2_r[A][B]) - SUMW'(kr2_r[B][A]);

    mvt_round #(.IW(SUMW), .SH(AXIS_FRAC)) u_cr_rnd (.din(cross_sum[i]), .dout(cr_rnd[i]));
    mvt_round #(.IW(MW), .SH(SCALE_FRAC)) u_sc_rnd (.din(m2_r[i]), .dout(sc_rnd[i]));
    mvt_round #(.IW(MW), .SH(TRIG_FRAC)) u_rc_rnd (.din(m2_r[i]), .dout(rc_rnd[i]));
    mvt_round #(.IW(CSPW), .SH(TRIG_FRAC)) u_cs_rnd (.din(csp4_r[i]), .dout(cs_rnd[i]));
    mvt_round #(.IW(KTPW), .SH(AXIS_FRAC)) u_kt_rnd (.din(ktp6_r[i]), .dout(kt_rnd[i]));

    // The scaled offset is limited to four times the coordinate range.
    assign sc_trunc[i] = sc_rnd[i][PT-1:0];
    assign sc_clamp[i] = (sc_trunc[i] > SPAN) ? SPAN :
                         (sc_trunc[i] < -SPAN) ? -SPAN : sc_trunc[i];

    always_comb begin
      case (cfg.mode)
        MODE_SCALE:  lin3_nxt[i] = LW'(off[i]) + LW'(sc_clamp[i]);
        MODE_ROTATE: lin3_nxt[i] = LW'(rc_rnd[i]);
        default:     lin3_nxt[i] = LW'(dir2_r[i]);
      endcase
    end

    assign acc5_nxt[i] = (cfg.mode == MODE_ROTATE)
                       ? AW'(off[i]) + AW'(lin4_r[i]) + AW'(cs_rnd[i])
                       : AW'(lin4_r[i]);

    assign fin[i] = (cfg.mode == MODE_ROTATE) ? FW'(acc6_r[i]) + FW'(kt_rnd[i])
                                              : FW'(acc6_r[i]);

    // Saturate when the coordinate's sign bit and the bits above it disagree.
    always_comb begin
      if (fin[i][FW-1:W-1] == {(FW-W+1){fin[i][FW-1]}}) begin
        out_nxt[i]  = fin[i][W-1:0];
        clip_nxt[i] = 1'b0;
      end else begin
        out_nxt[i]  = fin[i][FW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        clip_nxt[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      for (int i = 0; i < 3; i++) begin
        r1_r[i]   <= r1_nxt[i];
        dir1_r[i] <= dir1_nxt[i];
      end
    end
    if (ctrl.en[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          kr2_r[i][j] <= KRW'(k[i]) * KRW'(r1_r[j]);
        end
        m2_r[i]   <= MW'(r1_r[i]) * MW'(coef);
        dir2_r[i] <= dir1_r[i];
      end
    end
    if (ctrl.en[2]) begin
      dot3_r <= dot_rnd;
      for (int i = 0; i < 3; i++) begin
        cr3_r[i]  <= cr_rnd[i];
        lin3_r[i] <= lin3_nxt[i];
      end
    end
    if (ctrl.en[3]) begin
      tp4_r <= TPW'(dot3_r) * TPW'(omc);
      for (int i = 0; i < 3; i++) begin
        csp4_r[i] <= CSPW'(cr3_r[i]) * CSPW'(cfg.sin);
        lin4_r[i] <= lin3_r[i];
      end
    end
    if (ctrl.en[4]) begin
      t5_r <= t_rnd;
      for (int i = 0; i < 3; i++) begin
        acc5_r[i] <= acc5_nxt[i];
      end
    end
    if (ctrl.en[5]) begin
      for (int i = 0; i < 3; i++) begin
        ktp6_r[i] <= KTPW'(k[i]) * KTPW'(t5_r);
        acc6_r[i] <= acc5_r[i];
      end
    end
    if (ctrl.en[6]) begin
      clip7_r <= |clip_nxt;
      for (int i = 0; i < 3; i++) begin
        out7_r[i] <= out_nxt[i];
      end
    end
  end

  assign out_x   = out7_r[0];
  assign out_y   = out7_r[1];
  assign out_z   = out7_r[2];
  assign clipped = clip7_r;
endmodule

@@ src/mesh_vertex_transform_unit.sv @@
// Pipeline: a vertex transferred in loads the first of seven register stages and passes
// through them in order; the last stage's register drives the result on the output.
// Throughput: one vertex per cycle unless stalled; a stage reloads as its item moves on.
// Output stalls back up only as far as the first empty stage, so bubbles are squeezed out.
// Reset (rst_n low at a clock edge) empties the pipeline and returns every configuration
// register to its default: translate mode, zero offset, x axis, unit scale, zero angle.
module mesh_vertex_transform_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  mvt_in_if.sink     in_vtx,
  mvt_out_if.source  out_vtx,
  mvt_cfg_if.sink    cfg_wr
);
  import mvt_pkg::*;

  cfg_t                          cfg;
  logic signed [COORD_WIDTH-1:0] off [3];
  pipe_ctrl_t                    ctrl;

  mvt_cfg_regs #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg),
    .off    (off)
  );

  mvt_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vtx.valid),
    .out_ready (out_vtx.ready),
    .in_ready  (in_vtx.ready),
    .ctrl      (ctrl)
  );

  mvt_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk     (clk),
    .ctrl    (ctrl),
    .cfg     (cfg),
    .off     (off),
    .in_x    (in_vtx.in_x),
    .in_y    (in_vtx.in_y),
    .in_z    (in_vtx.in_z),
    .out_x   (out_vtx.out_x),
    .out_y   (out_vtx.out_y),
    .out_z   (out_vtx.out_z),
    .clipped (out_vtx.clipped)
  );

  assign out_vtx.valid = ctrl.vld[NUM_STAGES-1];
endmodule
